// ===== sv/wips_pkg.sv =====
// Package for the wave interference pixel shader: codes, field widths and constants.
`timescale 1ns / 1ps
`default_nettype none

package wips_pkg;

  localparam int unsigned WORD_W   = 13;
  localparam int unsigned SLOT_W   = 12;
  localparam int unsigned COLOR_W  = 12;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned SCNT_W   = 4;

  localparam int unsigned NEAR_LIMIT = 128 * 128;
  localparam int unsigned NEAR_SHIFT = 4;
  localparam int unsigned FAR_SHIFT  = 9;
  localparam int unsigned FAR_OFFSET = (NEAR_LIMIT << (FAR_SHIFT - NEAR_SHIFT)) - NEAR_LIMIT;

  localparam logic [CFG_W-1:0] MIN_COLORS = CFG_W'(2);
  localparam logic [CFG_W-1:0] MAX_COLORS = CFG_W'(4096);

  localparam logic [CFG_W-1:0]  RST_COLOR_COUNT  = CFG_W'(192);
  localparam logic [SCNT_W-1:0] RST_SOURCE_COUNT = SCNT_W'(3);
  localparam logic [CFG_W-1:0]  RST_TABLE_LENGTH = CFG_W'(2242);

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_TABLE  = 2'd1,
    KIND_SOURCE = 2'd2
  } wips_kind_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_COLOR_COUNT  = 2'd0,
    CFG_SOURCE_COUNT = 2'd1,
    CFG_TABLE_LENGTH = 2'd2
  } wips_cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_MOD,
    S_PUSH
  } wips_state_e;

endpackage

`default_nettype wire

// ===== sv/wips_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wips_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/wave_interference_pixel_shader_core.sv =====
// Top level of the wave interference pixel shader: sequencer, distance pipe, table, remainder.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_stall_o   | kind, coord_x, coord_y, slot, height_word
//   out     | output    | out_valid_o/out_stall_i | color_index
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Load words are taken in the idle state. A pixel word runs distance and table
// lookup (one wave-table read per source per cycle), then SUM_W remainder steps of the
// bit-serial modulo unit and a push state.
// Reset clears control state and source positions and resets the configuration; the wave table
// is not cleared. A finished result waits in the output register while new words are taken;
// a later pixel result waits in the push state until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module wave_interference_pixel_shader_core
  import wips_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned MAX_SOURCES = 8,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [COORD_BITS-1:0] coord_x_i,
  input  wire logic [COORD_BITS-1:0] coord_y_i,
  input  wire logic [SLOT_W-1:0]     slot_i,
  input  wire logic [WORD_W-1:0]     height_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [COLOR_W-1:0]    color_index_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_AW-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned SIDX   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned SRC_CW = $clog2(MAX_SOURCES + 1);
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned D2_W   = SQ_W + 1;
  localparam int unsigned SUMD_W = ((D2_W > 19) ? D2_W : 19) + 1;
  localparam int unsigned IDX_W  = SUMD_W - FAR_SHIFT;
  localparam int unsigned SUM_W  = WORD_W + $clog2(MAX_SOURCES + 1);
  localparam int unsigned BC_W   = $clog2(SUM_W + 1);

  // configuration
  logic [CFG_W-1:0]  color_cnt_q;
  logic [SCNT_W-1:0] src_cnt_q;
  logic [CFG_W-1:0]  tbl_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_cnt_q <= RST_COLOR_COUNT;
      src_cnt_q   <= RST_SOURCE_COUNT;
      tbl_len_q   <= RST_TABLE_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_COUNT:  color_cnt_q <= cfg_data_i;
        CFG_SOURCE_COUNT: src_cnt_q   <= cfg_data_i[SCNT_W-1:0];
        CFG_TABLE_LENGTH: tbl_len_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  wips_state_e state_q, state_d;
  logic        in_acc, pix_acc, issue, run_done, mod_last, push_ok;
  logic        out_vld_q;
  logic [SRC_CW-1:0] k_q, n_q;
  logic [BC_W-1:0]   bit_cnt_q;
  logic              s1_vld_q, s2_vld_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign pix_acc  = in_acc && (kind_i == KIND_PIXEL);
  assign run_done = (k_q == n_q) && !s1_vld_q && !s2_vld_q;
  assign mod_last = (bit_cnt_q == BC_W'(1));
  assign push_ok  = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (pix_acc) state_d = S_RUN;
      S_RUN:  if (run_done) state_d = S_MOD;
      S_MOD:  if (mod_last) state_d = S_PUSH;
      S_PUSH: if (push_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    issue      = (state_q == S_RUN) && (k_q < n_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // source positions
  logic [COORD_BITS-1:0] src_x_q [MAX_SOURCES];
  logic [COORD_BITS-1:0] src_y_q [MAX_SOURCES];
  logic                  src_we;

  assign src_we = in_acc && (kind_i == KIND_SOURCE) && (32'(slot_i) < MAX_SOURCES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
        src_x_q[i] <= '0;
        src_y_q[i] <= '0;
      end
    end else if (src_we) begin
      src_x_q[slot_i[SIDX-1:0]] <= coord_x_i;
      src_y_q[slot_i[SIDX-1:0]] <= coord_y_i;
    end
  end

  // wave table
  logic             tbl_we;
  logic [AW-1:0]    tbl_raddr;
  logic [WORD_W-1:0] tbl_rdata;

  assign tbl_we = in_acc && (kind_i == KIND_TABLE) && (32'(slot_i) < TABLE_DEPTH);

  wips_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(slot_i)),
    .wdata_i (height_word_i),
    .re_i    (s1_vld_q),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // pixel latch and clamped settings
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [SRC_CW-1:0]     n_d;
  logic [CFG_W-1:0]      mod_q, mod_d;

  always_comb begin
    if (src_cnt_q == '0) begin
      n_d = SRC_CW'(1);
    end else if (32'(src_cnt_q) > MAX_SOURCES) begin
      n_d = SRC_CW'(MAX_SOURCES);
    end else begin
      n_d = SRC_CW'(src_cnt_q);
    end
    if (color_cnt_q < MIN_COLORS) begin
      mod_d = MIN_COLORS;
    end else if (color_cnt_q > MAX_COLORS) begin
      mod_d = MAX_COLORS;
    end else begin
      mod_d = color_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      px_q  <= coord_x_i;
      py_q  <= coord_y_i;
      mod_q <= mod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      n_q <= '0;
    end else if (pix_acc) begin
      k_q <= '0;
      n_q <= n_d;
    end else if (issue) begin
      k_q <= k_q + SRC_CW'(1);
    end
  end

  // stage 1: squared axis distances
  logic [COORD_BITS-1:0] sx, sy, dx, dy;
  logic [SQ_W-1:0]       sq_x_q, sq_y_q;

  assign sx = src_x_q[k_q[SIDX-1:0]];
  assign sy = src_y_q[k_q[SIDX-1:0]];
  assign dx = (px_q >= sx) ? (px_q - sx) : (sx - px_q);
  assign dy = (py_q >= sy) ? (py_q - sy) : (sy - py_q);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      sq_x_q <= SQ_W'(dx) * SQ_W'(dx);
      sq_y_q <= SQ_W'(dy) * SQ_W'(dy);
    end
  end

  // stage 2: compress to table index, issue read
  logic [D2_W-1:0]   d2;
  logic [SUMD_W-1:0] far_sum;
  logic [IDX_W-1:0]  idx;
  logic              hit_q;

  always_comb begin
    d2      = D2_W'(sq_x_q) + D2_W'(sq_y_q);
    far_sum = SUMD_W'(d2) + SUMD_W'(FAR_OFFSET);
    if (32'(d2) < NEAR_LIMIT) begin
      idx = IDX_W'(d2 >> NEAR_SHIFT);
    end else begin
      idx = IDX_W'(far_sum >> FAR_SHIFT);
    end
    tbl_raddr = AW'(idx);
  end

  always_ff @(posedge clk_i) begin
    hit_q <= (32'(idx) < 32'(tbl_len_q)) && (32'(idx) < TABLE_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  // stage 3: accumulate, then bit-serial remainder
  logic [SUM_W-1:0] sum_q;
  logic [CFG_W-1:0] rem_q, rem_sh;

  assign rem_sh = {rem_q[CFG_W-2:0], sum_q[SUM_W-1]};

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      sum_q <= '0;
    end else if (s2_vld_q && hit_q) begin
      sum_q <= sum_q + SUM_W'(tbl_rdata);
    end else if (state_q == S_MOD) begin
      sum_q <= {sum_q[SUM_W-2:0], 1'b0};
    end
    if (state_q == S_RUN) begin
      rem_q <= '0;
    end else if (state_q == S_MOD) begin
      rem_q <= (rem_sh >= mod_q) ? (rem_sh - mod_q) : rem_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q <= '0;
    end else if (state_q == S_RUN) begin
      bit_cnt_q <= BC_W'(SUM_W);
    end else if (state_q == S_MOD) begin
      bit_cnt_q <= bit_cnt_q - BC_W'(1);
    end
  end

  // output register
  logic [COLOR_W-1:0] color_q;
  logic               push;

  assign push = (state_q == S_PUSH) && push_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      color_q <= rem_q[COLOR_W-1:0];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign color_index_o = color_q;

  // checks
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD || state_q == S_PUSH) |-> (rem_q < mod_q))
    else $error("remainder not below modulus");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (k_q <= n_q))
    else $error("source counter past source count");

  a_result_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_PUSH))
    else $error("result word without push");

  a_lookup_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> $past(state_q == S_RUN))
    else $error("table lookup outside pixel run");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the wave interference pixel shader core: random words against a color predictor.
`timescale 1ns / 1ps

module tb;
  import wips_pkg::*;

  localparam int unsigned WAVE_DEPTH   = 4096;
  localparam int unsigned N_SOURCES    = 8;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_WORDS  = 92;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    logic [1:0]        kind;
    logic [11:0]       x;
    logic [11:0]       y;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] height;
  } shader_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          kind_in = '0;
  logic [11:0]         x_in = '0;
  logic [11:0]         y_in = '0;
  logic [SLOT_W-1:0]   slot_in = '0;
  logic [WORD_W-1:0]   height_in = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COLOR_W-1:0]  color_out;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_idx = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  shader_word_t        pending_words[$];
  logic [COLOR_W-1:0]  expected_colors[$];

  // configuration, shared by the generator and the predictor; only changed while idle
  logic [CFG_W-1:0]    cfg_colors  = RST_COLOR_COUNT;
  logic [SCNT_W-1:0]   cfg_sources = RST_SOURCE_COUNT;
  logic [CFG_W-1:0]    cfg_length  = RST_TABLE_LENGTH;

  // predictor state, advanced on accepted words
  logic [WORD_W-1:0]   pred_wave [WAVE_DEPTH];
  logic [11:0]         pred_src_x [N_SOURCES];
  logic [11:0]         pred_src_y [N_SOURCES];

  // generator view, advanced as words are queued
  bit                  gen_written [WAVE_DEPTH];
  logic [11:0]         gen_src_x [N_SOURCES];
  logic [11:0]         gen_src_y [N_SOURCES];

  int                  idle_mode = IDLE_NONE;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         queued_count = 0;

  wave_interference_pixel_shader_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind_in),
    .coord_x_i    (x_in),
    .coord_y_i    (y_in),
    .slot_i       (slot_in),
    .height_word_i(height_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .color_index_o(color_out),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    for (int i = 0; i < N_SOURCES; i++) begin
      pred_src_x[i] = '0;
      pred_src_y[i] = '0;
      gen_src_x[i]  = '0;
      gen_src_y[i]  = '0;
    end
    for (int i = 0; i < WAVE_DEPTH; i++) begin
      pred_wave[i]   = '0;
      gen_written[i] = 1'b0;
    end
  end

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned wave_index(input logic [11:0] px, input logic [11:0] py,
                                             input logic [11:0] sx, input logic [11:0] sy);
    int unsigned dx;
    int unsigned dy;
    int unsigned d2;
    dx = (px >= sx) ? px - sx : sx - px;
    dy = (py >= sy) ? py - sy : sy - py;
    d2 = dx * dx + dy * dy;
    if (d2 < NEAR_LIMIT) return d2 >> NEAR_SHIFT;
    return (d2 + FAR_OFFSET) >> FAR_SHIFT;
  endfunction

  function automatic int unsigned active_sources();
    int unsigned n;
    n = cfg_sources;
    if (n < 1) n = 1;
    if (n > N_SOURCES) n = N_SOURCES;
    return n;
  endfunction

  function automatic logic [COLOR_W-1:0] color_of_pixel(input logic [11:0] px,
                                                        input logic [11:0] py);
    int unsigned modulus;
    int unsigned sum;
    int unsigned idx;
    modulus = cfg_colors;
    if (modulus < MIN_COLORS) modulus = MIN_COLORS;
    if (modulus > MAX_COLORS) modulus = MAX_COLORS;
    sum = 0;
    for (int unsigned k = 0; k < active_sources(); k++) begin
      idx = wave_index(px, py, pred_src_x[k], pred_src_y[k]);
      if (idx < cfg_length && idx < WAVE_DEPTH) sum += pred_wave[idx];
    end
    return COLOR_W'(sum % modulus);
  endfunction

  function automatic void apply_word(input shader_word_t w);
    case (w.kind)
      KIND_PIXEL: expected_colors.push_back(color_of_pixel(w.x, w.y));
      KIND_TABLE: if (w.slot < WAVE_DEPTH) pred_wave[w.slot] = w.height;
      KIND_SOURCE: begin
        if (w.slot < N_SOURCES) begin
          pred_src_x[w.slot] = w.x;
          pred_src_y[w.slot] = w.y;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_height();
    if ($urandom_range(0, 7) == 0) return WORD_W'(4096);
    return WORD_W'($urandom_range(0, 4096));
  endfunction

  function automatic void queue_word(input logic [1:0] kind, input logic [11:0] x,
                                     input logic [11:0] y, input logic [SLOT_W-1:0] slot,
                                     input logic [WORD_W-1:0] height);
    shader_word_t w;
    w.kind = kind;
    w.x = x;
    w.y = y;
    w.slot = slot;
    w.height = height;
    pending_words.push_back(w);
    queued_count++;
    if (kind == KIND_TABLE && slot < WAVE_DEPTH) gen_written[slot] = 1'b1;
    if (kind == KIND_SOURCE && slot < N_SOURCES) begin
      gen_src_x[slot] = x;
      gen_src_y[slot] = y;
    end
  endfunction

  // any table entry the pixel will read gets a word first, so no unwritten entry is read
  function automatic void queue_pixel(input logic [11:0] x, input logic [11:0] y);
    int unsigned idx;
    for (int unsigned k = 0; k < active_sources(); k++) begin
      idx = wave_index(x, y, gen_src_x[k], gen_src_y[k]);
      if (idx < cfg_length && idx < WAVE_DEPTH && !gen_written[idx])
        queue_word(KIND_TABLE, 12'($urandom), 12'($urandom), SLOT_W'(idx), random_height());
    end
    queue_word(KIND_PIXEL, x, y, 12'($urandom), random_height());
  endfunction

  function automatic logic [11:0] near_coord(input logic [11:0] c, input int unsigned reach);
    int t;
    t = int'(c) + int'($urandom_range(0, 2 * reach)) - int'(reach);
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return 12'(t);
  endfunction

  function automatic void queue_random();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, active_sources() - 1);
    if (r < 30) begin
      queue_pixel(12'($urandom), 12'($urandom));
    end else if (r < 60) begin
      queue_pixel(near_coord(gen_src_x[k], 1300), near_coord(gen_src_y[k], 1300));
    end else if (r < 75) begin
      queue_word(KIND_TABLE, 12'($urandom), 12'($urandom), SLOT_W'($urandom), random_height());
    end else if (r < 88) begin
      if ($urandom_range(0, 9) == 0)
        queue_word(KIND_SOURCE, 12'($urandom), 12'($urandom),
                   SLOT_W'($urandom_range(N_SOURCES, 4095)), random_height());
      else
        queue_word(KIND_SOURCE, 12'($urandom), 12'($urandom),
                   SLOT_W'($urandom_range(0, N_SOURCES - 1)), random_height());
    end else if (r < 93) begin
      queue_word(KIND_UNUSED, 12'($urandom), 12'($urandom), SLOT_W'($urandom), random_height());
    end else begin
      queue_pixel(near_coord(gen_src_x[k], 200), near_coord(gen_src_y[k], 200));
    end
  endfunction

  function automatic bit roll_idle(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int send_pct();
    if (idle_mode == IDLE_SEND) return 50;
    if (idle_mode == IDLE_BOTH) return 21;
    return 0;
  endfunction

  function automatic int recv_pct();
    if (idle_mode == IDLE_RECV) return 50;
    if (idle_mode == IDLE_BOTH) return 21;
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  task automatic cfg_program(input logic [CFG_W-1:0] colors, input logic [SCNT_W-1:0] sources,
                             input logic [CFG_W-1:0] length);
    cfg_colors  = colors;
    cfg_sources = sources;
    cfg_length  = length;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_COLOR_COUNT;
    cfg_data <= colors;
    @(posedge clk);
    cfg_idx  <= CFG_SOURCE_COUNT;
    cfg_data <= CFG_W'(sources);
    @(posedge clk);
    cfg_idx  <= CFG_TABLE_LENGTH;
    cfg_data <= length;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_colors.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // driver: a word stays on the port until taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_word(pending_words[0]);
        pending_words.delete(0);
      end
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() != 0 && !roll_idle(send_pct())) begin
          in_valid  <= 1'b1;
          kind_in   <= pending_words[0].kind;
          x_in      <= pending_words[0].x;
          y_in      <= pending_words[0].y;
          slot_in   <= pending_words[0].slot;
          height_in <= pending_words[0].height;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : color_monitor
    logic [COLOR_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("color word with none pending", 0, color_out);
        end else begin
          want = expected_colors.pop_front();
          if (color_out !== want) report_mismatch("color_index", want, color_out);
        end
      end
      out_stall <= roll_idle(recv_pct());
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d words pending, %0d colors outstanding", $time,
               pending_words.size(), expected_colors.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words under the reset configuration
    queue_word(KIND_SOURCE, 12'd0, 12'd0, 12'd0, '0);
    queue_word(KIND_SOURCE, 12'd4095, 12'd4095, 12'd1, '0);
    queue_word(KIND_SOURCE, 12'd2048, 12'd2048, 12'd2, '0);
    queue_word(KIND_SOURCE, 12'd4095, 12'd0, 12'd7, '0);
    queue_word(KIND_SOURCE, 12'd111, 12'd222, 12'd8, '0);
    queue_word(KIND_SOURCE, 12'd333, 12'd444, 12'd4095, WORD_W'(4096));
    queue_word(KIND_TABLE, 12'd0, 12'd0, 12'd0, WORD_W'(4096));
    queue_word(KIND_TABLE, 12'd4095, 12'd4095, 12'd4095, '0);
    queue_word(KIND_TABLE, 12'd0, 12'd0, 12'd1024, WORD_W'(4096));
    queue_word(KIND_UNUSED, 12'd4095, 12'd4095, 12'd4095, WORD_W'(4096));
    queue_pixel(12'd0, 12'd0);
    queue_pixel(12'd4095, 12'd4095);
    queue_pixel(12'd2048, 12'd2048);
    queue_pixel(12'd127, 12'd0);
    queue_pixel(12'd128, 12'd0);
    queue_pixel(12'd1260, 12'd0);
    queue_pixel(12'd0, 12'd4095);
    queue_pixel(12'd4095, 12'd0);
    queue_word(KIND_TABLE, 12'd0, 12'd0, 12'd0, '0);
    queue_pixel(12'd0, 12'd0);
    wait_idle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: cfg_program(CFG_W'(2), SCNT_W'(1), CFG_W'(1));
        1: cfg_program(CFG_W'(4096), SCNT_W'(8), CFG_W'(4096));
        2: cfg_program(CFG_W'(0), SCNT_W'(0), CFG_W'(0));
        3: cfg_program(CFG_W'(8191), SCNT_W'(15), CFG_W'(8191));
        default: cfg_program(CFG_W'($urandom_range(2, 4096)), SCNT_W'($urandom_range(1, 8)),
                             CFG_W'($urandom_range(1, 4096)));
      endcase
      @(negedge clk);
      idle_mode = ph % 4;
      // table fills queued ahead of pixels count toward the phase budget
      phase_start = queued_count;
      while (queued_count - phase_start < PHASE_WORDS) queue_random();
      wait_idle();
    end

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
